@@ src/line_rasterizer_unit_macros.svh @@
// Assertion macros shared by the line rasterizer checker.
`ifndef LINE_RASTERIZER_UNIT_MACROS_SVH
`define LINE_RASTERIZER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LRAST_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LRAST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lrast_pkg.sv @@
// Shared types and constants of the line rasterizer.
package lrast_pkg;

    localparam int COORD_W     = 6;
    localparam int IN_W        = 8;
    localparam int CHAR_W      = 8;
    localparam int DIM_W       = 7;
    localparam int ERR_W       = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int MAX_DIM_DEF = 64;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ORDER,
        ST_INIT,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic load;
        logic order;
        logic init;
        logic step;
    } core_ctrl_t;

    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic               last;
    } core_stat_t;

endpackage

@@ src/lrast_ifs.sv @@
// Valid/ready channel interfaces of the line rasterizer.
interface lrast_cmd_if;
    logic                                valid;
    logic                                ready;
    logic signed [lrast_pkg::IN_W-1:0]   start_x;
    logic signed [lrast_pkg::IN_W-1:0]   start_y;
    logic signed [lrast_pkg::IN_W-1:0]   end_x;
    logic signed [lrast_pkg::IN_W-1:0]   end_y;
    logic        [lrast_pkg::CHAR_W-1:0] fill_char;

    modport source (output valid, start_x, start_y, end_x, end_y, fill_char, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, fill_char, output ready);
endinterface

interface lrast_pix_if;
    logic                                valid;
    logic                                ready;
    logic [lrast_pkg::COORD_W-1:0]       pixel_x;
    logic [lrast_pkg::COORD_W-1:0]       pixel_y;
    logic [lrast_pkg::CHAR_W-1:0]        pixel_char;
    logic                                last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_char, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_char, last_pixel, output ready);
endinterface

interface lrast_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lrast_pkg::CFG_IDX_W-1:0]     index;
    logic [lrast_pkg::DIM_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/lrast_core.sv @@
// Bresenham stepping datapath: ordering, error init and per-pixel step.
module lrast_core (
    input  logic                          clk,
    input  lrast_pkg::core_ctrl_t         ctrl,
    input  logic [lrast_pkg::COORD_W-1:0] x1,
    input  logic [lrast_pkg::COORD_W-1:0] y1,
    input  logic [lrast_pkg::COORD_W-1:0] x2,
    input  logic [lrast_pkg::COORD_W-1:0] y2,
    output lrast_pkg::core_stat_t         stat
);

    localparam int CW = lrast_pkg::COORD_W;
    localparam int EW = lrast_pkg::ERR_W;

    logic [CW-1:0]        x1_reg, y1_reg, x2_reg, y2_reg;
    logic [CW-1:0]        a_reg, end_reg, b_reg, dmin_reg, dmaj_reg;
    logic                 steep_reg, dir_neg_reg;
    logic signed [EW-1:0] err_reg, inc_pos_reg;

    logic [CW-1:0]        adx, ady;
    logic                 steep, swap;
    logic [CW-1:0]        maj1, maj2, min1, min2;
    logic signed [EW-1:0] op_a, op_b, sum;
    logic signed [EW-1:0] dmin2, dmaj2;
    logic                 err_pos;

    // Endpoint ordering and major/minor selection
    always_comb
    begin
        adx   = (x2_reg >= x1_reg) ? x2_reg - x1_reg : x1_reg - x2_reg;
        ady   = (y2_reg >= y1_reg) ? y2_reg - y1_reg : y1_reg - y2_reg;
        steep = (ady >= adx);
        swap  = steep ? (y1_reg > y2_reg) : (x1_reg > x2_reg);
        if (steep)
        begin
            maj1 = swap ? y2_reg : y1_reg;
            maj2 = swap ? y1_reg : y2_reg;
            min1 = swap ? x2_reg : x1_reg;
            min2 = swap ? x1_reg : x2_reg;
        end
        else
        begin
            maj1 = swap ? x2_reg : x1_reg;
            maj2 = swap ? x1_reg : x2_reg;
            min1 = swap ? y2_reg : y1_reg;
            min2 = swap ? y1_reg : y2_reg;
        end
    end

    // Shared error adder: initial value during INIT, update during RUN
    always_comb
    begin
        dmin2   = signed'({2'b00, dmin_reg, 1'b0});
        dmaj2   = signed'({2'b00, dmaj_reg, 1'b0});
        err_pos = !err_reg[EW-1] && (|err_reg);
        if (ctrl.init)
        begin
            op_a = dmin2;
            op_b = -signed'({3'b000, dmaj_reg});
        end
        else
        begin
            op_a = err_reg;
            op_b = err_pos ? inc_pos_reg : dmin2;
        end
        sum = op_a + op_b;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x1_reg <= x1;
            y1_reg <= y1;
            x2_reg <= x2;
            y2_reg <= y2;
        end
        if (ctrl.order)
        begin
            steep_reg   <= steep;
            a_reg       <= maj1;
            end_reg     <= maj2;
            b_reg       <= min1;
            dmaj_reg    <= maj2 - maj1;
            dir_neg_reg <= (min2 < min1);
            dmin_reg    <= (min2 < min1) ? min1 - min2 : min2 - min1;
        end
        if (ctrl.init)
        begin
            err_reg     <= sum;
            inc_pos_reg <= dmin2 - dmaj2;
        end
        if (ctrl.step)
        begin
            a_reg   <= a_reg + 1'b1;
            err_reg <= sum;
            if (err_pos)
                b_reg <= dir_neg_reg ? b_reg - 1'b1 : b_reg + 1'b1;
        end
    end

    assign stat.px   = steep_reg ? b_reg : a_reg;
    assign stat.py   = steep_reg ? a_reg : b_reg;
    assign stat.last = (a_reg == end_reg);

endmodule

@@ src/line_rasterizer_unit.sv @@
// Top level of the line rasterizer: command intake, canvas registers, pixel output.
//
// The block turns one line command into a stream of pixel words, one word per
// pixel of an integer Bresenham line, with last_pixel set on the final word. A
// command with any endpoint off the canvas (negative, or at or above the canvas
// width or height, where a size above MAX_DIM counts as MAX_DIM) is taken and
// produces no words. An accepted line of N pixels (N up to MAX_DIM) is taken in
// IDLE, then ORDER orders the endpoints and picks the major axis, INIT seeds the
// error term, and RUN steps the pixels through the single shared error adder,
// advancing only while the output slot is free. The command side stays not ready
// until the last pixel has been handed to the output register; the next command is
// taken while that last word still waits on the output. The output register
// lets a stalled sink hold the line without losing words. Canvas registers are
// written through the config channel, which is always ready; index 0 is the
// width, index 1 the height, both reset to 64.
module line_rasterizer_unit #(
    parameter int MAX_DIM = lrast_pkg::MAX_DIM_DEF
) (
    input logic         clk,
    input logic         rst_n,
    lrast_cmd_if.sink   cmd,
    lrast_pix_if.source pix,
    lrast_cfg_if.sink   cfg
);

    localparam int CW = lrast_pkg::COORD_W;
    localparam int DW = lrast_pkg::DIM_W;
    localparam logic [DW-1:0] MAX_DIM_V = DW'(MAX_DIM);

    lrast_pkg::state_t     state_reg, state_next;
    lrast_pkg::core_ctrl_t ctrl;
    lrast_pkg::core_stat_t stat;

    logic [DW-1:0]                  width_reg, height_reg;
    logic [DW-1:0]                  w_eff, h_eff;
    logic                           in_range;
    logic                           out_valid_reg, out_valid_next;
    logic [CW-1:0]                  px_reg, py_reg;
    logic                           last_reg;
    logic [lrast_pkg::CHAR_W-1:0]   char_reg, out_char_reg;
    logic                           slot_free;
    logic                           emit;

    // Clamp canvas size to MAX_DIM, then check all four coordinates
    assign w_eff = (width_reg  > MAX_DIM_V) ? MAX_DIM_V : width_reg;
    assign h_eff = (height_reg > MAX_DIM_V) ? MAX_DIM_V : height_reg;

    assign in_range = !cmd.start_x[7] && (cmd.start_x[DW-1:0] < w_eff) &&
                      !cmd.end_x[7]   && (cmd.end_x[DW-1:0]   < w_eff) &&
                      !cmd.start_y[7] && (cmd.start_y[DW-1:0] < h_eff) &&
                      !cmd.end_y[7]   && (cmd.end_y[DW-1:0]   < h_eff);

    // Output slot is free when empty or drained this cycle
    assign slot_free = !out_valid_reg || pix.ready;

    // Config registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lrast_pkg::DIM_RESET;
            height_reg <= lrast_pkg::DIM_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                lrast_pkg::REG_CANVAS_WIDTH:  width_reg  <= cfg.data;
                lrast_pkg::REG_CANVAS_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Sequencer: take command, order endpoints, seed error, step pixels
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        cmd.ready  = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            lrast_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid && in_range)
                begin
                    ctrl.load  = 1'b1;
                    state_next = lrast_pkg::ST_ORDER;
                end
            end
            lrast_pkg::ST_ORDER:
            begin
                ctrl.order = 1'b1;
                state_next = lrast_pkg::ST_INIT;
            end
            lrast_pkg::ST_INIT:
            begin
                ctrl.init  = 1'b1;
                state_next = lrast_pkg::ST_RUN;
            end
            lrast_pkg::ST_RUN:
            begin
                // Advance only when the output word can be replaced
                if (slot_free)
                begin
                    emit      = 1'b1;
                    ctrl.step = 1'b1;
                    if (stat.last)
                        state_next = lrast_pkg::ST_IDLE;
                end
            end
            default:
                state_next = lrast_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lrast_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold the word while stalled, drop it once taken
    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (pix.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            char_reg <= cmd.fill_char;
        if (emit)
        begin
            px_reg       <= stat.px;
            py_reg       <= stat.py;
            last_reg     <= stat.last;
            out_char_reg <= char_reg;
        end
    end

    lrast_core u_core (
        .clk  (clk),
        .ctrl (ctrl),
        .x1   (cmd.start_x[CW-1:0]),
        .y1   (cmd.start_y[CW-1:0]),
        .x2   (cmd.end_x[CW-1:0]),
        .y2   (cmd.end_y[CW-1:0]),
        .stat (stat)
    );

    assign pix.valid      = out_valid_reg;
    assign pix.pixel_x    = px_reg;
    assign pix.pixel_y    = py_reg;
    assign pix.pixel_char = out_char_reg;
    assign pix.last_pixel = last_reg;

endmodule

@@ src/lrast_checker.sv @@
// Port-level checker of the line rasterizer and its bind.
`include "line_rasterizer_unit_macros.svh"

module lrast_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          pix_valid,
    input logic                          pix_ready,
    input logic [lrast_pkg::COORD_W-1:0] pix_x,
    input logic [lrast_pkg::COORD_W-1:0] pix_y,
    input logic [lrast_pkg::CHAR_W-1:0]  pix_char,
    input logic                          pix_last
);

    // A stalled word holds its contents
    `LRAST_ASSERT_NEXT(a_pix_hold, pix_valid && !pix_ready, pix_valid && $stable(pix_x) && $stable(pix_y) && $stable(pix_char) && $stable(pix_last), "pixel word changed while stalled")

    // No new command while a line still has pixels to come
    `LRAST_ASSERT_SAME(a_no_cmd_mid_line, pix_valid && !pix_last, !cmd_ready, "command ready in mid line")

    // A taken non-last pixel is followed at once by the next one, same char
    `LRAST_ASSERT_NEXT(a_line_cont, pix_valid && pix_ready && !pix_last, pix_valid && $stable(pix_char), "line broken or char changed")

    // A command taken over a stalled last word keeps that word in place
    `LRAST_ASSERT_NEXT(a_cmd_over_last, cmd_valid && cmd_ready && pix_valid && !pix_ready, pix_valid && pix_last, "held last word lost on command accept")

endmodule

bind line_rasterizer_unit lrast_checker u_lrast_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .pix_valid (pix.valid),
    .pix_ready (pix.ready),
    .pix_x     (pix.pixel_x),
    .pix_y     (pix.pixel_y),
    .pix_char  (pix.pixel_char),
    .pix_last  (pix.last_pixel)
);

@@ test/line_rasterizer_unit_checker.sv @@
// Pixel stream checker: tracks canvas size, traces each accepted line, compares pixel words.
module line_rasterizer_unit_checker
    import lrast_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic clk,
    input  logic rst_n,
    lrast_cmd_if cmd,
    lrast_pix_if pix,
    lrast_cfg_if cfg,
    output int   fail_count,
    output int   pending_pixels
);

    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [CHAR_W-1:0]  ch;
        logic               last;
    } pixel_word_t;

    logic [DIM_W-1:0] canvas_w = DIM_RESET;
    logic [DIM_W-1:0] canvas_h = DIM_RESET;
    pixel_word_t      line_pixels_q[$];

    // Queue the pixel words of one line command under the current canvas size.
    task automatic rasterize_line(input logic signed [IN_W-1:0] sx, sy, ex, ey,
                                  input logic [CHAR_W-1:0] ch);
        int x1, y1, x2, y2, w, h, adx, ady, tmp;
        int dmaj, dmin, dir, err, pos, stop, minor;
        bit steep;
        pixel_word_t word;
        x1 = sx;
        y1 = sy;
        x2 = ex;
        y2 = ey;
        w = (int'(canvas_w) > MAX_DIM) ? MAX_DIM : int'(canvas_w);
        h = (int'(canvas_h) > MAX_DIM) ? MAX_DIM : int'(canvas_h);
        if (x1 < 0 || y1 < 0 || x2 < 0 || y2 < 0 || x1 >= w || x2 >= w || y1 >= h || y2 >= h)
            return;
        adx = (x2 >= x1) ? x2 - x1 : x1 - x2;
        ady = (y2 >= y1) ? y2 - y1 : y1 - y2;
        steep = !(ady < adx);
        // order the endpoints along the major axis
        if ((steep && y1 > y2) || (!steep && x1 > x2))
        begin
            tmp = x1; x1 = x2; x2 = tmp;
            tmp = y1; y1 = y2; y2 = tmp;
        end
        if (steep)
        begin
            pos = y1; stop = y2; minor = x1; dmaj = y2 - y1; dmin = x2 - x1;
        end
        else
        begin
            pos = x1; stop = x2; minor = y1; dmaj = x2 - x1; dmin = y2 - y1;
        end
        dir = 1;
        if (dmin < 0)
        begin
            dir = -1;
            dmin = -dmin;
        end
        err = 2 * dmin - dmaj;
        for (; pos <= stop; pos++)
        begin
            word.px   = COORD_W'(steep ? minor : pos);
            word.py   = COORD_W'(steep ? pos : minor);
            word.ch   = ch;
            word.last = (pos == stop);
            line_pixels_q.push_back(word);
            if (err > 0)
            begin
                minor += dir;
                err += 2 * (dmin - dmaj);
            end
            else
                err += 2 * dmin;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_word_t want;
        if (!rst_n)
        begin
            canvas_w   = DIM_RESET;
            canvas_h   = DIM_RESET;
            fail_count = 0;
            line_pixels_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_CANVAS_WIDTH:  canvas_w = cfg.data;
                    REG_CANVAS_HEIGHT: canvas_h = cfg.data;
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready)
            begin
                if (line_pixels_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] unexpected pixel word: x=%0d y=%0d char=%h last=%b",
                                 $realtime, pix.pixel_x, pix.pixel_y, pix.pixel_char,
                                 pix.last_pixel);
                end
                else
                begin
                    want = line_pixels_q.pop_front();
                    if (pix.pixel_x !== want.px || pix.pixel_y !== want.py ||
                        pix.pixel_char !== want.ch || pix.last_pixel !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("[%0t] pixel word: exp x=%0d y=%0d char=%h last=%b, %s",
                                     $realtime, want.px, want.py, want.ch, want.last,
                                     $sformatf("got x=%0d y=%0d char=%h last=%b",
                                               pix.pixel_x, pix.pixel_y, pix.pixel_char,
                                               pix.last_pixel));
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                rasterize_line(cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y, cmd.fill_char);
        end
        pending_pixels = line_pixels_q.size();
    end

endmodule

@@ test/line_rasterizer_unit_tb.sv @@
// Testbench top of the line rasterizer: clock, reset, line commands, canvas writes, verdict.
module line_rasterizer_unit_tb;
    import lrast_pkg::*;

    localparam int MAX_DIM      = MAX_DIM_DEF;
    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 8;
    // Long output stall: far longer than a full line, so the block backs up.
    localparam int LONG_HOLD    = 400;
    // Cycles to let a rejected command leave the block before a canvas write.
    localparam int SETTLE       = 8;
    // Tail after the last expected word: a full line plus its setup cycles.
    localparam int DRAIN        = 80;
    // Time limit for the whole run, several times the slowest correct run.
    localparam int RUN_LIMIT    = 6_000_000;

    // Canvas setting and length of each random phase; phase 5 draws its own size.
    localparam int NUM_PHASES = 8;
    localparam int PHASE_W [NUM_PHASES] = '{64, 64, 100, 1, 64, 0, 0, 127};
    localparam int PHASE_H [NUM_PHASES] = '{64, 64, 1, 64, 64, 0, 30, 64};
    localparam int PHASE_N [NUM_PHASES] = '{18, 18, 16, 12, 18, 18, 4, 16};

    logic clk;
    logic rst_n;

    lrast_cmd_if cmd_ch ();
    lrast_pix_if pix_ch ();
    lrast_cfg_if cfg_ch ();

    int fail_count;
    int pending_pixels;

    // Set by the command process; the two sink flags are read by the pixel sink.
    int sink_hold_req = 0;
    bit src_idle_on   = 1'b0;
    bit sink_idle_on  = 1'b0;

    // Effective canvas size as the stimulus sees it (values above MAX_DIM clip).
    int cur_w = MAX_DIM;
    int cur_h = MAX_DIM;

    line_rasterizer_unit #(.MAX_DIM(MAX_DIM)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .pix   (pix_ch),
        .cfg   (cfg_ch)
    );

    line_rasterizer_unit_checker #(.MAX_DIM(MAX_DIM)) u_pixel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd_ch),
        .pix            (pix_ch),
        .cfg            (cfg_ch),
        .fail_count     (fail_count),
        .pending_pixels (pending_pixels)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(RUN_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Pixel sink: draw a wait before each word, or honor a long hold when asked.
    // Ready only drops at a falling edge, never twice in one step.
    initial
    begin : pixel_sink
        int gap;
        pix_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (sink_hold_req > 0)
            begin
                gap = sink_hold_req;
                sink_hold_req = 0;
            end
            else
                gap = sink_idle_on ? $urandom_range(0, 7) : 0;
            if (gap > 0)
            begin
                pix_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pix_ch.ready <= 1'b1;
            do @(posedge clk); while (!(pix_ch.valid && pix_ch.ready));
            @(negedge clk);
        end
    end

    // Offer one line command; entered and left at a falling edge. Valid stays
    // high into the next command when no gap is drawn.
    task automatic send_line(input logic signed [IN_W-1:0] sx, sy, ex, ey,
                             input logic [CHAR_W-1:0] ch);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.start_x   <= sx;
        cmd_ch.start_y   <= sy;
        cmd_ch.end_x     <= ex;
        cmd_ch.end_y     <= ey;
        cmd_ch.fill_char <= ch;
        cmd_ch.valid     <= 1'b1;
        do @(posedge clk); while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    // Drop valid, then hold until every expected word is out and the block is quiet.
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (pending_pixels != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write one canvas register; leaves cfg valid high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_ch.index <= idx;
        cfg_ch.data  <= DIM_W'(value);
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    // Resize the canvas, only with the block idle.
    task automatic set_canvas(input int w, input int h);
        wait_idle();
        write_reg(REG_CANVAS_WIDTH, w);
        write_reg(REG_CANVAS_HEIGHT, h);
        cfg_ch.valid <= 1'b0;
        cur_w = (w > MAX_DIM) ? MAX_DIM : w;
        cur_h = (h > MAX_DIM) ? MAX_DIM : h;
    endtask

    function automatic int pick_inside(input int dim);
        return $urandom_range(0, dim - 1);
    endfunction

    // Point within +/-8 of base, clamped onto the canvas.
    function automatic int pick_near(input int base, input int dim);
        int v;
        v = base + int'($urandom_range(0, 16)) - 8;
        return (v < 0) ? 0 : (v >= dim) ? dim - 1 : v;
    endfunction

    // One random command: mostly lines on the canvas, the rest noise or edge misses.
    task automatic send_random_line();
        int kind, x1, y1, x2, y2;
        kind = $urandom_range(0, 99);
        if (cur_w == 0 || cur_h == 0 || kind < 12)
        begin
            // raw noise over the whole 8-bit range
            x1 = $urandom_range(0, 255);
            y1 = $urandom_range(0, 255);
            x2 = $urandom_range(0, 255);
            y2 = $urandom_range(0, 255);
        end
        else
        begin
            x1 = pick_inside(cur_w);
            y1 = pick_inside(cur_h);
            if (kind < 70)
            begin
                // short line, cheap to drain
                x2 = pick_near(x1, cur_w);
                y2 = pick_near(y1, cur_h);
            end
            else
            begin
                x2 = pick_inside(cur_w);
                y2 = pick_inside(cur_h);
            end
            // push one coordinate off the canvas
            if (kind < 20)
            begin
                case ($urandom_range(0, 3))
                    0: x1 = cur_w;
                    1: y2 = cur_h;
                    2: x2 = -1;
                    default: y1 = -1 - int'($urandom_range(0, 127));
                endcase
            end
        end
        send_line(IN_W'(x1), IN_W'(y1), IN_W'(x2), IN_W'(y2), CHAR_W'($urandom_range(0, 255)));
    endtask

    initial
    begin : stimulus
        int w, h;
        // known values on every input from time zero
        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.start_x   = '0;
        cmd_ch.start_y   = '0;
        cmd_ch.end_x     = '0;
        cmd_ch.end_y     = '0;
        cmd_ch.fill_char = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_CANVAS_WIDTH;
        cfg_ch.data      = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed lines on the reset canvas (64 x 64).
        send_line(0, 0, 0, 0, 8'h00);          // single point, equal endpoints
        send_line(63, 63, 63, 63, 8'hFF);      // far corner
        send_line(0, 5, 63, 5, 8'h2A);         // full-width horizontal
        send_line(63, 10, 0, 10, 8'h55);       // horizontal, reversed
        send_line(7, 0, 7, 63, 8'hAA);         // full-height vertical
        send_line(7, 63, 7, 0, 8'h80);         // vertical, reversed
        send_line(0, 0, 63, 63, 8'h7F);        // diagonal takes the steep path
        send_line(63, 0, 0, 63, 8'h01);        // anti-diagonal
        send_line(0, 0, 63, 20, 8'h41);        // shallow, rising
        send_line(0, 40, 50, 3, 8'h42);        // shallow, falling
        send_line(50, 3, 0, 40, 8'h43);        // shallow, endpoints swapped
        send_line(2, 0, 20, 63, 8'h44);        // steep, rising
        send_line(40, 1, 3, 60, 8'h45);        // steep, falling
        send_line(10, 10, 11, 10, 8'h46);      // two-pixel horizontal
        send_line(0, 0, 5, 4, 8'h47);          // minor just under major
        send_line(-1, 0, 5, 5, 8'h48);         // negative start column
        send_line(0, 0, 5, -128, 8'h49);       // most negative end row
        send_line(64, 0, 0, 0, 8'h4A);         // column one past the edge
        send_line(0, 0, 0, 127, 8'h4B);        // largest positive row

        // Canvas extremes.
        set_canvas(1, 1);
        send_line(0, 0, 0, 0, 8'hC3);          // only pixel of a 1 x 1 canvas
        send_line(1, 0, 0, 0, 8'hC4);          // off a 1 x 1 canvas
        set_canvas(0, 64);
        send_line(0, 0, 0, 0, 8'hC5);          // zero width rejects everything
        set_canvas(127, 127);
        send_line(63, 0, 0, 63, 8'hC6);        // oversize clips to MAX_DIM
        send_line(0, 64, 0, 0, 8'hC7);         // still off past MAX_DIM

        // Random phases, one canvas size each, a full drain between them.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            w = PHASE_W[p];
            h = PHASE_H[p];
            if (p == 5)
            begin
                w = $urandom_range(2, 63);
                h = $urandom_range(2, 63);
            end
            set_canvas(w, h);
            if (p == 1)
            begin
                // Stall the output for a long stretch while full lines keep coming,
                // so the block backs up into its command side.
                src_idle_on = 1'b0;
                sink_idle_on = 1'b0;
                sink_hold_req = LONG_HOLD;
                for (int k = 0; k < 6; k++)
                    send_line(0, IN_W'(k), 63, IN_W'(63 - k), CHAR_W'($urandom_range(0, 255)));
            end
            for (int i = 0; i < PHASE_N[p]; i++)
            begin
                // redraw idling every few commands; zero keeps back-to-back stretches
                if (i % 6 == 0)
                begin
                    src_idle_on = ($urandom_range(0, 2) != 0);
                    sink_idle_on = ($urandom_range(0, 2) != 0);
                end
                send_random_line();
            end
        end

        // Wind down: drain everything, then a full line's worth of cycles.
        wait_idle();
        repeat (DRAIN) @(negedge clk);
        if (fail_count == 0 && pending_pixels == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ line_rasterizer_unit.f @@
+incdir+src
src/lrast_pkg.sv
src/lrast_ifs.sv
src/lrast_core.sv
src/line_rasterizer_unit.sv
src/lrast_checker.sv
test/line_rasterizer_unit_checker.sv
test/line_rasterizer_unit_tb.sv
